// ===== rtl/core/beacon_frame_suspect_classifier_macros.svh =====
`ifndef BEACON_FRAME_SUSPECT_CLASSIFIER_MACROS_SVH
`define BEACON_FRAME_SUSPECT_CLASSIFIER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BFSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bfsc_pkg.sv =====
package bfsc_pkg;

    localparam int MAX_FRAME_LEN_DEF = 4095;
    localparam int VENDOR_ROWS_DEF   = 8;
    localparam int TABLE_ROWS        = 8;
    localparam int TABLE_PREFIXES    = 4;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [7:0]  BEACON_BYTE    = 8'h80;
    localparam logic [15:0] PRIVACY_MASK   = 16'h0010;
    localparam logic [15:0] MIN_CAPABILITY = 16'h0001;
    localparam logic [7:0]  DS_TAG_ID      = 8'h03;
    localparam logic [7:0]  DS_TAG_LEN     = 8'h01;

    localparam int ADDR_FIRST_POS = 10;
    localparam int ADDR_LAST_POS  = 15;
    localparam int CAP_LO_POS     = 34;
    localparam int CAP_HI_POS     = 35;
    localparam int SSID_LEN_POS   = 37;
    localparam int SSID_TAG_BASE  = 38;
    localparam int MIN_BEACON_LEN = 36;
    localparam int DS_TAIL_LEN    = 3;

    localparam logic [2:0] GATE_ANY  = 3'b001;
    localparam logic [2:0] GATE_OPEN = 3'b010;
    localparam logic [2:0] GATE_PROT = 3'b100;

    typedef enum logic [1:0] {
        REASON_PREFIX  = 2'd0,
        REASON_MINIMAL = 2'd1,
        REASON_DUAL    = 2'd2
    } reason_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] source_address;
        reason_t     reason;
        logic [3:0]  vendor_index;
        logic        network_open;
    } alert_t;

    localparam logic [2:0] VENDOR_GATE [TABLE_ROWS] = '{
        GATE_OPEN, GATE_ANY, GATE_OPEN, GATE_OPEN,
        GATE_PROT, GATE_ANY, GATE_ANY, GATE_ANY
    };

    localparam logic [2:0] VENDOR_COUNT [TABLE_ROWS] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1
    };

    localparam logic [23:0] VENDOR_PREFIX [TABLE_ROWS][TABLE_PREFIXES] = '{
        '{24'h00C0CA, 24'h000000, 24'h000000, 24'h000000},
        '{24'h001337, 24'h000000, 24'h000000, 24'h000000},
        '{24'h1CBFCE, 24'h000000, 24'h000000, 24'h000000},
        '{24'h0CEFAF, 24'h000000, 24'h000000, 24'h000000},
        '{24'h02C0CA, 24'h021337, 24'h000000, 24'h000000},
        '{24'h000A00, 24'h000C43, 24'h000CE7, 24'h0017A5},
        '{24'h9CEFD5, 24'h9CE5D5, 24'h000000, 24'h000000},
        '{24'hDEADBE, 24'h000000, 24'h000000, 24'h000000}
    };

    // first row whose prefix and security gate both match, rows when none
    function automatic logic [4:0] vendor_lookup(
        input logic [23:0] prefix,
        input logic        open,
        input int          rows
    );
        logic [4:0] result;
        logic       found;
        logic       row_hit;
        logic       gate_ok;
        result = 5'(rows);
        found  = 1'b0;
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            row_hit = 1'b0;
            for (int j = 0; j < TABLE_PREFIXES; j++)
            begin
                if (3'(j) < VENDOR_COUNT[i] && VENDOR_PREFIX[i][j] == prefix)
                begin
                    row_hit = 1'b1;
                end
            end
            gate_ok = (VENDOR_GATE[i] == GATE_ANY)
                   || (open && VENDOR_GATE[i] == GATE_OPEN)
                   || (!open && VENDOR_GATE[i] == GATE_PROT);
            if (!found && i < rows && row_hit && gate_ok)
            begin
                result = 5'(i);
                found  = 1'b1;
            end
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/bfsc_parser.sv =====
`include "beacon_frame_suspect_classifier_macros.svh"

module bfsc_parser
    import bfsc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int VENDOR_ROWS   = VENDOR_ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] frame_byte,
    input  logic       last_of_frame,
    input  logic       frame_is_mgmt,
    output alert_t     alert
);

    localparam int PW = $clog2(MAX_FRAME_LEN + 1);
    localparam int CW = (PW + 1 > 10) ? PW + 1 : 10;

    logic [PW-1:0] pos_reg, pos_next;
    logic          beacon_reg, beacon_next;
    logic          mgmt_reg, mgmt_next;
    logic [47:0]   addr_reg, addr_next;
    logic [15:0]   cap_reg, cap_next;
    logic [7:0]    ssid_len_reg, ssid_len_next;
    logic [7:0]    tag_reg, tag_next;
    logic [7:0]    tag_len_reg, tag_len_next;

    logic [CW-1:0] idx;
    logic [CW-1:0] frame_len;
    logic [CW-1:0] ssid_end;
    logic          known;
    logic          open;
    logic          qualifies;
    logic [4:0]    vendor;
    logic          pref_hit;
    logic          min_hit;

    assign idx       = CW'(pos_reg);
    assign frame_len = idx + CW'(1);
    assign ssid_end  = CW'(SSID_TAG_BASE) + CW'(ssid_len_reg);
    assign known     = pos_reg < PW'(MAX_FRAME_LEN);

    always_comb
    begin
        pos_next      = pos_reg;
        beacon_next   = beacon_reg;
        mgmt_next     = mgmt_reg;
        addr_next     = addr_reg;
        cap_next      = cap_reg;
        ssid_len_next = ssid_len_reg;
        tag_next      = tag_reg;
        tag_len_next  = tag_len_reg;
        if (known)
        begin
            if (idx == '0)
            begin
                beacon_next = (frame_byte == BEACON_BYTE);
                mgmt_next   = frame_is_mgmt;
            end
            if (idx >= CW'(ADDR_FIRST_POS) && idx <= CW'(ADDR_LAST_POS))
            begin
                addr_next = {addr_reg[39:0], frame_byte};
            end
            if (idx == CW'(CAP_LO_POS))
            begin
                cap_next = {cap_reg[15:8], frame_byte};
            end
            if (idx == CW'(CAP_HI_POS))
            begin
                cap_next = {frame_byte, cap_reg[7:0]};
            end
            if (idx == CW'(SSID_LEN_POS))
            begin
                ssid_len_next = frame_byte;
            end
            if (idx == ssid_end)
            begin
                tag_next = frame_byte;
            end
            if (idx == ssid_end + CW'(1))
            begin
                tag_len_next = frame_byte;
            end
            pos_next = pos_reg + PW'(1);
        end
    end

    // decision on the state as it stands after this byte
    assign open      = (cap_next & PRIVACY_MASK) == '0;
    assign qualifies = mgmt_next && beacon_next && frame_len >= CW'(MIN_BEACON_LEN);
    assign vendor    = vendor_lookup(addr_next[47:24], open, VENDOR_ROWS);
    assign pref_hit  = vendor != 5'(VENDOR_ROWS);
    assign min_hit   = known && cap_next == MIN_CAPABILITY
                    && frame_len == ssid_end + CW'(DS_TAIL_LEN)
                    && tag_next == DS_TAG_ID && tag_len_next == DS_TAG_LEN;

    always_comb
    begin
        alert.hit            = last_of_frame && qualifies && (pref_hit || min_hit);
        alert.source_address = addr_next;
        alert.vendor_index   = vendor[3:0];
        alert.network_open   = open;
        priority if (pref_hit && min_hit)
        begin
            alert.reason = REASON_DUAL;
        end
        else if (pref_hit)
        begin
            alert.reason = REASON_PREFIX;
        end
        else
        begin
            alert.reason = REASON_MINIMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            beacon_reg   <= 1'b0;
            mgmt_reg     <= 1'b0;
            addr_reg     <= '0;
            cap_reg      <= '0;
            ssid_len_reg <= '0;
            tag_reg      <= '0;
            tag_len_reg  <= '0;
        end
        else if (take)
        begin
            if (last_of_frame)
            begin
                pos_reg      <= '0;
                beacon_reg   <= 1'b0;
                mgmt_reg     <= 1'b0;
                addr_reg     <= '0;
                cap_reg      <= '0;
                ssid_len_reg <= '0;
                tag_reg      <= '0;
                tag_len_reg  <= '0;
            end
            else
            begin
                pos_reg      <= pos_next;
                beacon_reg   <= beacon_next;
                mgmt_reg     <= mgmt_next;
                addr_reg     <= addr_next;
                cap_reg      <= cap_next;
                ssid_len_reg <= ssid_len_next;
                tag_reg      <= tag_next;
                tag_len_reg  <= tag_len_next;
            end
        end
    end

    `BFSC_ASSERT_NEXT(a_clear_after_last, take && last_of_frame, pos_reg == '0, "position not cleared after last byte")
    `BFSC_ASSERT_NOW(a_pos_saturates, 1'b1, pos_reg <= PW'(MAX_FRAME_LEN), "position beyond saturation")
    `BFSC_ASSERT_NOW(a_beacon_mid_frame, beacon_reg || mgmt_reg, pos_reg != '0, "first-byte flags set with no byte taken")

endmodule

// ===== rtl/core/beacon_frame_suspect_classifier.sv =====
// channel  | dir | tdata (low bit up)                                  | side bits
// s_axis   | in  | frame_byte 8, rx_channel 4, rx_rssi 8, pad 4        | tlast, tuser = mgmt
// m_axis   | out | address 48, channel 4, rssi 8, vendor 4, open 1, 7 | tuser = alert_reason
//
// one byte a cycle while s_axis_tready is high, the verdict comes from the byte's own cycle with no loop
// an alert is registered in the output buffer when the last byte of its frame is taken
// a two-entry output buffer keeps s_axis_tready high while one alert waits
// rst_n clears the frame state and both output entries at once
// s_axis_tready is registered and drops only while both entries are full
`include "beacon_frame_suspect_classifier_macros.svh"

module beacon_frame_suspect_classifier
    import bfsc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF,
    parameter int VENDOR_ROWS   = VENDOR_ROWS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // frame_byte, rx_channel, rx_rssi
    input  logic                 s_axis_tlast,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // frame_is_mgmt
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // source_address, alert_channel, alert_rssi,
                                                // vendor_index, network_open
    output logic [M_TUSER_W-1:0] m_axis_tuser   // alert_reason
);

    logic                 take;
    alert_t               alert;
    logic [M_TDATA_W-1:0] alert_data;
    logic                 push;
    logic                 pop;

    logic                 main_valid_reg;
    logic [M_TDATA_W-1:0] main_data_reg;
    reason_t              main_reason_reg;
    logic                 skid_valid_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    reason_t              skid_reason_reg;

    assign take = s_axis_tvalid && s_axis_tready;

    bfsc_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .VENDOR_ROWS   (VENDOR_ROWS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .frame_byte    (s_axis_tdata[7:0]),
        .last_of_frame (s_axis_tlast),
        .frame_is_mgmt (s_axis_tuser[0]),
        .alert         (alert)
    );

    assign alert_data = {7'b0, alert.network_open, alert.vendor_index,
                         s_axis_tdata[19:12], s_axis_tdata[11:8], alert.source_address};

    assign push = take && alert.hit;
    assign pop  = main_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg   <= skid_data_reg;
                main_reason_reg <= skid_reason_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_data_reg   <= alert_data;
                main_reason_reg <= alert.reason;
            end
            else
            begin
                skid_data_reg   <= alert_data;
                skid_reason_reg <= alert.reason;
            end
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = main_data_reg;
    assign m_axis_tuser  = main_reason_reg;

    `BFSC_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid entry without main entry")
    `BFSC_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_axis_tready, skid_valid_reg, "skid entry lost while stalled")
    `BFSC_ASSERT_NOW(a_vendor_on_prefix, main_valid_reg && main_reason_reg != REASON_MINIMAL, main_data_reg[63:60] != 4'(VENDOR_ROWS) || VENDOR_ROWS == 16, "prefix alert without a vendor row")

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import bfsc_pkg::*;

    localparam int ROWS          = VENDOR_ROWS_DEF;
    localparam int MAX_LEN       = MAX_FRAME_LEN_DEF;
    localparam int LIMIT         = 800000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE        = 20;
    localparam int RANDOM_BYTES  = 1500;
    localparam int CALM_BYTES    = 1250;
    localparam int DIRECTED_ROWS = 24;
    localparam int BUF_LEN       = 4200;

    typedef enum logic [1:0] {
        TAIL_RANDOM,
        TAIL_DS,
        TAIL_DS_LONG,
        TAIL_DS_BADLEN
    } tail_t;

    typedef struct packed {
        logic [47:0] addr;
        logic [3:0]  chan;
        logic [7:0]  rssi;
        reason_t     reason;
        logic [3:0]  vendor;
        logic        open;
    } alert_rec_t;

    typedef struct packed {
        logic [7:0]  first;
        logic        mgmt;
        logic [23:0] prefix;
        logic [15:0] cap;
        logic [7:0]  ssid;
        tail_t       tail;
        logic [12:0] len;
        logic [3:0]  chan;
        logic [7:0]  rssi;
        logic        typed;
        logic        hit;
        reason_t     reason;
        logic [3:0]  vendor;
    } frame_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // frame_byte, rx_channel, rx_rssi
    logic                 s_axis_tlast;
    logic [S_TUSER_W-1:0] s_axis_tuser;   // frame_is_mgmt
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // source_address, alert_channel, alert_rssi,
                                          // vendor_index, network_open
    logic [M_TUSER_W-1:0] m_axis_tuser;   // alert_reason

    beacon_frame_suspect_classifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [23:0] vendor_prefix [TABLE_ROWS][TABLE_PREFIXES] = '{
        '{24'h00C0CA, 24'h000000, 24'h000000, 24'h000000},
        '{24'h001337, 24'h000000, 24'h000000, 24'h000000},
        '{24'h1CBFCE, 24'h000000, 24'h000000, 24'h000000},
        '{24'h0CEFAF, 24'h000000, 24'h000000, 24'h000000},
        '{24'h02C0CA, 24'h021337, 24'h000000, 24'h000000},
        '{24'h000A00, 24'h000C43, 24'h000CE7, 24'h0017A5},
        '{24'h9CEFD5, 24'h9CE5D5, 24'h000000, 24'h000000},
        '{24'hDEADBE, 24'h000000, 24'h000000, 24'h000000}
    };
    int          vendor_count [TABLE_ROWS] = '{1, 1, 1, 1, 2, 4, 2, 1};
    logic [2:0]  vendor_gate [TABLE_ROWS] = '{
        GATE_OPEN, GATE_ANY, GATE_OPEN, GATE_OPEN,
        GATE_PROT, GATE_ANY, GATE_ANY, GATE_ANY
    };

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h80, 1'b1, 24'h00C0CA, 16'h0000, 8'd4, TAIL_RANDOM, 13'd60, 4'd0, 8'h80,
          1'b1, 1'b1, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h00C0CA, 16'h0010, 8'd4, TAIL_RANDOM, 13'd60, 4'd3, 8'h10,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h02C0CA, 16'h0010, 8'd8, TAIL_RANDOM, 13'd70, 4'd15, 8'h7F,
          1'b1, 1'b1, REASON_PREFIX, 4'd4},
        '{8'h80, 1'b1, 24'h021337, 16'h0000, 8'd8, TAIL_RANDOM, 13'd50, 4'd5, 8'h00,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h021337, 16'h0001, 8'd5, TAIL_DS, 13'd0, 4'd7, 8'hC4,
          1'b1, 1'b1, REASON_MINIMAL, 4'd8},
        '{8'h80, 1'b1, 24'hDEADBE, 16'h0001, 8'd3, TAIL_DS, 13'd0, 4'd9, 8'hFF,
          1'b1, 1'b1, REASON_DUAL, 4'd7},
        '{8'h80, 1'b1, 24'h0017A5, 16'hFFFF, 8'd0, TAIL_RANDOM, 13'd40, 4'd1, 8'h01,
          1'b1, 1'b1, REASON_PREFIX, 4'd5},
        '{8'h80, 1'b1, 24'h9CE5D5, 16'h0000, 8'd12, TAIL_RANDOM, 13'd64, 4'd2, 8'hA0,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h001337, 16'h0010, 8'd2, TAIL_RANDOM, 13'd44, 4'd4, 8'h33,
          1'b1, 1'b1, REASON_PREFIX, 4'd1},
        '{8'h80, 1'b1, 24'h1CBFCE, 16'h0020, 8'd6, TAIL_RANDOM, 13'd52, 4'd6, 8'hE0,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h0CEFAF, 16'h0011, 8'd6, TAIL_RANDOM, 13'd52, 4'd8, 8'h20,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'hDEADBE, 16'h0000, 8'd0, TAIL_RANDOM, 13'd35, 4'd10, 8'h90,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'hDEADBE, 16'h0000, 8'd0, TAIL_RANDOM, 13'd36, 4'd11, 8'h91,
          1'b1, 1'b1, REASON_PREFIX, 4'd7},
        '{8'h80, 1'b1, 24'h000000, 16'h0000, 8'd0, TAIL_RANDOM, 13'd1, 4'd12, 8'h92,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b0, 24'hDEADBE, 16'h0001, 8'd2, TAIL_DS, 13'd0, 4'd13, 8'h93,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h50, 1'b1, 24'hDEADBE, 16'h0001, 8'd2, TAIL_DS, 13'd0, 4'd14, 8'h94,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h123456, 16'h0001, 8'd0, TAIL_DS, 13'd0, 4'd0, 8'hB0,
          1'b1, 1'b1, REASON_MINIMAL, 4'd8},
        '{8'h80, 1'b1, 24'hABCDEF, 16'h0001, 8'd255, TAIL_DS, 13'd0, 4'd15, 8'h80,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'hABCDEF, 16'h0001, 8'd4, TAIL_DS_LONG, 13'd0, 4'd1, 8'h7F,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'hABCDEF, 16'h0001, 8'd4, TAIL_DS_BADLEN, 13'd0, 4'd2, 8'h00,
          1'b1, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h00C0CA, 16'h0001, 8'd7, TAIL_DS, 13'd0, 4'd3, 8'hEE,
          1'b1, 1'b1, REASON_DUAL, 4'd0},
        '{8'h80, 1'b1, 24'h000C43, 16'h0001, 8'd9, TAIL_DS, 13'd0, 4'd6, 8'h5A,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'h9CEFD5, 16'h0001, 8'd1, TAIL_RANDOM, 13'd4095, 4'd4, 8'h11,
          1'b0, 1'b0, REASON_PREFIX, 4'd0},
        '{8'h80, 1'b1, 24'hDEADBE, 16'h0001, 8'd1, TAIL_RANDOM, 13'd4096, 4'd5, 8'h22,
          1'b1, 1'b1, REASON_PREFIX, 4'd7}
    };

    // frame parser state, mirrors the block
    int unsigned frame_pos      = 0;
    logic        frame_beacon   = 1'b0;
    logic        frame_mgmt     = 1'b0;
    logic [47:0] frame_addr     = '0;
    logic [15:0] frame_cap      = '0;
    logic [7:0]  frame_ssid_len = '0;
    logic [7:0]  frame_tag_id   = '0;
    logic [7:0]  frame_tag_len  = '0;

    alert_rec_t  pending_alerts [$];
    logic [7:0]  frame_buf [BUF_LEN];
    int          frame_len;

    bit          use_typed = 1'b0;
    bit          typed_hit = 1'b0;
    alert_rec_t  typed_alert;
    bit          calm = 1'b0;
    bit          rush = 1'b0;
    bit          hold_req = 1'b0;
    int          bytes_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic classify_byte(
        input  logic [7:0] b,
        input  logic       last,
        input  logic       mgmt,
        input  logic [3:0] chan,
        input  logic [7:0] rssi,
        output alert_rec_t rec
    );
        int unsigned idx;
        int unsigned ssid_end;
        int unsigned len;
        int unsigned vend;
        logic        known;
        logic        open;
        logic        prefix_hit;
        logic        minimal_hit;
        logic        row_match;
        logic        gate_ok;
        classify_byte = 1'b0;
        rec = '0;
        idx = frame_pos;
        known = idx < MAX_LEN;
        ssid_end = SSID_TAG_BASE + frame_ssid_len;
        if (known)
        begin
            if (idx == 0)
            begin
                frame_beacon = (b == BEACON_BYTE);
                frame_mgmt = mgmt;
            end
            if (idx >= ADDR_FIRST_POS && idx <= ADDR_LAST_POS)
            begin
                frame_addr = {frame_addr[39:0], b};
            end
            if (idx == CAP_LO_POS)
            begin
                frame_cap[7:0] = b;
            end
            if (idx == CAP_HI_POS)
            begin
                frame_cap[15:8] = b;
            end
            if (idx == SSID_LEN_POS)
            begin
                frame_ssid_len = b;
            end
            if (idx == ssid_end)
            begin
                frame_tag_id = b;
            end
            if (idx == ssid_end + 1)
            begin
                frame_tag_len = b;
            end
            frame_pos = idx + 1;
        end
        if (last)
        begin
            len = idx + 1;
            open = (frame_cap & PRIVACY_MASK) == 16'h0000;
            if (frame_mgmt && frame_beacon && len >= MIN_BEACON_LEN)
            begin
                vend = ROWS;
                for (int i = 0; i < ROWS && i < TABLE_ROWS; i++)
                begin
                    row_match = 1'b0;
                    for (int j = 0; j < vendor_count[i]; j++)
                    begin
                        if (vendor_prefix[i][j] == frame_addr[47:24])
                        begin
                            row_match = 1'b1;
                        end
                    end
                    gate_ok = (vendor_gate[i] == GATE_ANY)
                           || (open && vendor_gate[i] == GATE_OPEN)
                           || (!open && vendor_gate[i] == GATE_PROT);
                    if (vend == ROWS && row_match && gate_ok)
                    begin
                        vend = i;
                    end
                end
                prefix_hit = vend < ROWS;
                minimal_hit = known && frame_cap == MIN_CAPABILITY
                           && len == ssid_end + DS_TAIL_LEN
                           && frame_tag_id == DS_TAG_ID && frame_tag_len == DS_TAG_LEN;
                if (prefix_hit || minimal_hit)
                begin
                    rec.addr = frame_addr;
                    rec.chan = chan;
                    rec.rssi = rssi;
                    rec.reason = (prefix_hit && minimal_hit) ? REASON_DUAL
                               : (prefix_hit ? REASON_PREFIX : REASON_MINIMAL);
                    rec.vendor = 4'(vend);
                    rec.open = open;
                    classify_byte = 1'b1;
                end
            end
            frame_pos = 0;
            frame_beacon = 1'b0;
            frame_mgmt = 1'b0;
            frame_addr = '0;
            frame_cap = '0;
            frame_ssid_len = '0;
            frame_tag_id = '0;
            frame_tag_len = '0;
        end
    endfunction

    function automatic void build_frame(
        input logic [7:0]  first,
        input logic [23:0] prefix,
        input logic [23:0] low,
        input logic [15:0] cap,
        input int          ssid,
        input tail_t       tail,
        input int          len
    );
        logic [47:0] addr;
        addr = {prefix, low};
        case (tail)
            TAIL_DS:        frame_len = SSID_TAG_BASE + ssid + DS_TAIL_LEN;
            TAIL_DS_LONG:   frame_len = SSID_TAG_BASE + ssid + DS_TAIL_LEN + 1;
            TAIL_DS_BADLEN: frame_len = SSID_TAG_BASE + ssid + DS_TAIL_LEN;
            default:        frame_len = len;
        endcase
        for (int i = 0; i < frame_len; i++)
        begin
            frame_buf[i] = 8'($urandom);
        end
        frame_buf[0] = first;
        for (int k = 0; k < 6; k++)
        begin
            frame_buf[ADDR_FIRST_POS + k] = addr[47 - 8 * k -: 8];
        end
        frame_buf[CAP_LO_POS] = cap[7:0];
        frame_buf[CAP_HI_POS] = cap[15:8];
        frame_buf[SSID_LEN_POS] = 8'(ssid);
        if (tail != TAIL_RANDOM)
        begin
            frame_buf[SSID_TAG_BASE + ssid] = DS_TAG_ID;
            frame_buf[SSID_TAG_BASE + ssid + 1] = (tail == TAIL_DS_BADLEN) ? 8'h02 : DS_TAG_LEN;
        end
    endfunction

    task automatic send_byte(
        input logic [7:0] b,
        input logic       last,
        input logic       mgmt,
        input logic [3:0] chan,
        input logic [7:0] rssi
    );
        alert_rec_t rec;
        logic       hit;
        if (!calm && !rush && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, rssi, chan, b};
        s_axis_tlast  <= last;
        s_axis_tuser  <= mgmt;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        hit = classify_byte(b, last, mgmt, chan, rssi, rec);
        if (last && use_typed)
        begin
            hit = typed_hit;
            rec = typed_alert;
        end
        if (hit)
        begin
            pending_alerts.push_back(rec);
        end
        bytes_sent++;
    endtask

    // management flag matters only on the first byte, channel and rssi only on the last
    task automatic send_frame(
        input logic       mgmt,
        input logic [3:0] last_chan,
        input logic [7:0] last_rssi
    );
        logic last;
        for (int i = 0; i < frame_len; i++)
        begin
            last = (i == frame_len - 1);
            send_byte(frame_buf[i], last, (i == 0) ? mgmt : 1'($urandom),
                      last ? last_chan : 4'($urandom), last ? last_rssi : 8'($urandom));
        end
    endtask

    task automatic wait_for_alerts;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_alerts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : alert_check
        alert_rec_t got;
        alert_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.addr   = m_axis_tdata[47:0];
            got.chan   = m_axis_tdata[51:48];
            got.rssi   = m_axis_tdata[59:52];
            got.vendor = m_axis_tdata[63:60];
            got.open   = m_axis_tdata[64];
            got.reason = reason_t'(m_axis_tuser);
            if (pending_alerts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected alert: addr %h ch %0d rssi %0d reason %0d vendor %0d open %0d",
                             got.addr, got.chan, $signed(got.rssi), got.reason, got.vendor,
                             got.open);
                end
            end
            else
            begin
                want = pending_alerts.pop_front();
                if (got.addr !== want.addr || got.chan !== want.chan
                    || got.rssi !== want.rssi || got.reason !== want.reason
                    || got.vendor !== want.vendor || got.open !== want.open)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("alert mismatch: expected addr %h ch %0d rssi %0d reason %0d vendor %0d open %0d",
                                 want.addr, want.chan, $signed(want.rssi), want.reason,
                                 want.vendor, want.open);
                        $display("                got      addr %h ch %0d rssi %0d reason %0d vendor %0d open %0d",
                                 got.addr, got.chan, $signed(got.rssi), got.reason,
                                 got.vendor, got.open);
                    end
                end
            end
        end
    end

    initial
    begin
        frame_row_t  row;
        logic [23:0] low;
        int          kind;
        int          r;
        int          ssid;
        int          len;
        int          frames;
        int          random_start;
        tail_t       tail;
        logic [23:0] pfx;
        logic [15:0] cap;
        logic [7:0]  first;
        logic        mgmt;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            low = 24'($urandom);
            build_frame(row.first, row.prefix, low, row.cap, row.ssid, row.tail, row.len);
            use_typed = row.typed;
            typed_hit = row.hit;
            typed_alert.addr = {row.prefix, low};
            typed_alert.chan = row.chan;
            typed_alert.rssi = row.rssi;
            typed_alert.reason = row.reason;
            typed_alert.vendor = row.vendor;
            typed_alert.open = (row.cap & PRIVACY_MASK) == 16'h0000;
            send_frame(row.mgmt, row.chan, row.rssi);
        end
        use_typed = 1'b0;

        frames = 0;
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            ssid = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 255)
                                                : $urandom_range(0, 32);
            tail = tail_t'($urandom_range(0, 3));
            cap = 16'($urandom);
            pfx = 24'($urandom);
            first = BEACON_BYTE;
            mgmt = 1'b1;
            len = $urandom_range(MIN_BEACON_LEN, 96);
            if (kind < 40)
            begin
                r = $urandom_range(0, TABLE_ROWS - 1);
                pfx = vendor_prefix[r][$urandom_range(0, vendor_count[r] - 1)];
            end
            else if (kind < 75)
            begin
                cap = MIN_CAPABILITY;
                if ($urandom_range(0, 3) != 0)
                begin
                    tail = TAIL_DS;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    r = $urandom_range(0, TABLE_ROWS - 1);
                    pfx = vendor_prefix[r][$urandom_range(0, vendor_count[r] - 1)];
                end
            end
            else
            begin
                // noise: any first byte, any tag, any length
                mgmt = 1'($urandom);
                if ($urandom_range(0, 1) == 1)
                begin
                    first = 8'($urandom);
                end
                len = $urandom_range(1, 96);
            end
            build_frame(first, pfx, 24'($urandom), cap, ssid, tail, len);
            send_frame(mgmt, 4'($urandom), 8'($urandom));
            frames++;

            if (frames == 6)
            begin
                // receiver stalls while short alerting beacons keep coming
                hold_req = 1'b1;
                rush = 1'b1;
                repeat (8)
                begin
                    build_frame(BEACON_BYTE, 24'hDEADBE, 24'($urandom), 16'($urandom), 0,
                                TAIL_RANDOM, MIN_BEACON_LEN);
                    send_frame(1'b1, 4'($urandom), 8'($urandom));
                end
                rush = 1'b0;
            end
            if (frames == 14)
            begin
                wait_for_alerts();
            end
            if (bytes_sent - random_start >= CALM_BYTES)
            begin
                calm = 1'b1;
            end
        end

        wait_for_alerts();
        if (mismatches == 0 && pending_alerts.size() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
